>>> design/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types, codes and the setting value decode of the display controller
// command parser.
// ----------------------------------------------------------------------------
package gdc_pkg;

   // Field widths of the channels
   localparam int SETTING_W = 5;
   localparam int INDEX_W   = 4;
   localparam int VALUE_W   = 18;
   localparam int BYTE_W    = 8;
   localparam int STEP_W    = 4;
   localparam int DATA_W    = 64;

   // Command opcodes
   localparam logic [7:0] CMD_RESET    = 8'h00;
   localparam logic [7:0] CMD_BLANK    = 8'h0C;
   localparam logic [7:0] CMD_SYNC     = 8'h0E;
   localparam logic [7:0] CMD_PITCH    = 8'h47;
   localparam logic [7:0] CMD_CURPOS   = 8'h49;
   localparam logic [7:0] CMD_CURSETUP = 8'h4B;
   localparam logic [7:0] CMD_START    = 8'h6B;
   localparam logic [7:0] CMD_VSYNC    = 8'h6E;
   localparam logic [7:0] CMD_RAMLOAD  = 8'h70;
   localparam logic [7:0] CMD_NONE     = 8'hFF;

   // Parameter counts
   localparam logic [STEP_W-1:0] TIMING_BYTES = 4'd8;
   localparam logic [STEP_W-1:0] CURSOR_BYTES = 4'd3;

   // Setting codes
   localparam logic [SETTING_W-1:0] SET_DISPLAY_ENABLE = 5'd0;
   localparam logic [SETTING_W-1:0] SET_IDLE           = 5'd1;
   localparam logic [SETTING_W-1:0] SET_MASTER_SYNC    = 5'd2;
   localparam logic [SETTING_W-1:0] SET_PITCH          = 5'd3;
   localparam logic [SETTING_W-1:0] SET_RAM_BYTE       = 5'd4;
   localparam logic [SETTING_W-1:0] SET_CURSOR_ADDR    = 5'd5;
   localparam logic [SETTING_W-1:0] SET_CURSOR_ENABLE  = 5'd6;
   localparam logic [SETTING_W-1:0] SET_ROW_LINES      = 5'd7;
   localparam logic [SETTING_W-1:0] SET_BLINK_RATE     = 5'd8;
   localparam logic [SETTING_W-1:0] SET_BLINKING       = 5'd9;
   localparam logic [SETTING_W-1:0] SET_CURSOR_TOP     = 5'd10;
   localparam logic [SETTING_W-1:0] SET_CURSOR_BOTTOM  = 5'd11;
   localparam logic [SETTING_W-1:0] SET_DRAW_RETRACE   = 5'd12;
   localparam logic [SETTING_W-1:0] SET_REFRESH        = 5'd13;
   localparam logic [SETTING_W-1:0] SET_DISPLAY_MODE   = 5'd14;
   localparam logic [SETTING_W-1:0] SET_FRAMING        = 5'd15;
   localparam logic [SETTING_W-1:0] SET_ACTIVE_WORDS   = 5'd16;
   localparam logic [SETTING_W-1:0] SET_HSYNC_WIDTH    = 5'd17;
   localparam logic [SETTING_W-1:0] SET_VSYNC_WIDTH    = 5'd18;
   localparam logic [SETTING_W-1:0] SET_H_FRONT        = 5'd19;
   localparam logic [SETTING_W-1:0] SET_H_BACK         = 5'd20;
   localparam logic [SETTING_W-1:0] SET_V_FRONT        = 5'd21;
   localparam logic [SETTING_W-1:0] SET_ACTIVE_LINES   = 5'd22;
   localparam logic [SETTING_W-1:0] SET_V_BACK         = 5'd23;

   // One queued job: a run of consecutive setting codes decoded from data
   typedef struct packed {
      logic [SETTING_W-1:0] setting_first;
      logic [STEP_W-1:0]    last_offset;
      logic [INDEX_W-1:0]   index;
      logic [DATA_W-1:0]    data;
   } gdc_job_type;

   typedef struct packed {
      logic        valid;
      gdc_job_type job;
   } gdc_push_type;

   // Decode the value of one setting from a job's data word. For the
   // parameter-driven settings the data word is the parameter byte image,
   // byte i at bits [8i+7:8i].
   function automatic logic [VALUE_W-1:0] setting_value(
      input logic [SETTING_W-1:0] setting,
      input logic [DATA_W-1:0]    data
   );
      logic [VALUE_W-1:0] val;
      logic [5:0]         blink;
      blink = {1'b0, data[18:16], data[15:14]};
      if (blink == 6'd0) begin
         blink = 6'h20;
      end
      val = '0;
      unique case (setting)
         SET_DISPLAY_ENABLE: val = {17'd0, data[0]};
         SET_IDLE:           val = {17'd0, data[1]};
         SET_MASTER_SYNC:    val = {17'd0, data[0]};
         SET_PITCH:          val = {9'd0, data[8:0]};
         SET_RAM_BYTE:       val = {10'd0, data[7:0]};
         SET_CURSOR_ADDR:    val = data[17:0];
         SET_CURSOR_ENABLE:  val = {17'd0, data[7]};
         SET_ROW_LINES:      val = {13'd0, data[4:0]};
         SET_BLINK_RATE:     val = {11'd0, blink, 1'b0};
         SET_BLINKING:       val = {17'd0, ~data[13]};
         SET_CURSOR_TOP:     val = {13'd0, data[12:8]};
         SET_CURSOR_BOTTOM:  val = {13'd0, data[23:19]};
         SET_DRAW_RETRACE:   val = {17'd0, data[4]};
         SET_REFRESH:        val = {17'd0, data[2]};
         SET_DISPLAY_MODE:   val = {16'd0, data[5], data[1]};
         SET_FRAMING:        val = {16'd0, data[3], data[0]};
         SET_ACTIVE_WORDS:   val = {9'd0, 9'({1'b0, data[15:8]} + 9'd2)};
         SET_HSYNC_WIDTH:    val = {12'd0, 6'({1'b0, data[20:16]} + 6'd1)};
         SET_VSYNC_WIDTH:    val = {13'd0, data[25:24], data[23:21]};
         SET_H_FRONT:        val = {11'd0, 7'({1'b0, data[31:26]} + 7'd1)};
         SET_H_BACK:         val = {11'd0, 7'({1'b0, data[37:32]} + 7'd1)};
         SET_V_FRONT:        val = {12'd0, data[45:40]};
         SET_ACTIVE_LINES:   val = {8'd0, data[57:56], data[55:48]};
         SET_V_BACK:         val = {12'd0, data[63:58]};
         default:            val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> design/gdc_if.sv
// ----------------------------------------------------------------------------
// gdc_if
// Valid/ready channels of the command parser: request words in, setting
// updates out.
// ----------------------------------------------------------------------------
interface gdc_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface gdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  setting;
   logic [3:0]  index;
   logic [17:0] value;
   logic        last;

   modport source (output valid, output setting, output index, output value,
                   output last, input ready);
   modport sink   (input valid, input setting, input index, input value,
                   input last, output ready);
endinterface

>>> design/gdc_command_parser_top.sv
// ----------------------------------------------------------------------------
// gdc_command_parser_top
// Command and parameter decoder of a graphics display controller.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one queue word per request: op = 1 for a command byte,
//   op = 0 for a parameter byte, data_byte holds the opcode or value.
//   rsp_port carries setting updates (setting, index, value, last); last
//   marks the final update caused by a request. Requests that cause no
//   update (unknown commands, surplus parameters) produce nothing.
//   A request is decoded in the cycle it is accepted and queued as one job;
//   its first update goes through the job queue and the output register.
//   The expansion stage emits one update per cycle while rsp_port does not
//   stall. A request has 1 or 2 updates for most, 2 or 4 for a cursor setup
//   byte and 12 for the timing decode of a reset or sync command.
//   Requests are taken every cycle while the job queue (QUEUE_DEPTH jobs)
//   has room; when rsp_port stalls, the output register holds and the queue
//   fills, then req_port.ready drops.
//   Reset (synchronous) clears the active command to none, the parameter
//   step, the cursor address, the RAM write pointer, the queue and the
//   output register.
// ----------------------------------------------------------------------------
module gdc_command_parser_top #(
   parameter int PARAM_RAM_BYTES = 16,
   parameter int QUEUE_DEPTH     = 2
) (
   input  logic       clock,
   input  logic       reset,
   gdc_req_if.sink    req_port,
   gdc_rsp_if.source  rsp_port
);

   gdc_pkg::gdc_push_type push;
   gdc_pkg::gdc_job_type  head;
   logic                  queue_full;
   logic                  head_valid;
   logic                  pop;

   gdc_front #(
      .PARAM_RAM_BYTES (PARAM_RAM_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .queue_full (queue_full),
      .push       (push)
   );

   gdc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   gdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_port   (rsp_port)
   );

endmodule

>>> design/gdc_front.sv
// ----------------------------------------------------------------------------
// gdc_front
// Accepts command and parameter words, tracks the parser state and turns
// each request into at most one job for the expansion stage.
// ----------------------------------------------------------------------------
module gdc_front #(
   parameter int PARAM_RAM_BYTES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   gdc_req_if.sink               req_port,
   input  logic                  queue_full,
   output gdc_pkg::gdc_push_type push
);

   logic [7:0]                   active_cmd_ff, active_cmd_in;
   logic [gdc_pkg::STEP_W-1:0]   step_ff, step_in, step_nx;
   logic [gdc_pkg::VALUE_W-1:0]  cursor_ff, cursor_in;
   logic [gdc_pkg::INDEX_W-1:0]  ptr_ff, ptr_in;
   logic [7:0]                   bytes_ff [8];
   logic [7:0]                   bytes_new [8];
   logic                         byte_we;
   logic [gdc_pkg::DATA_W-1:0]   image;
   logic                         accept;
   logic [7:0]                   v;

   assign req_port.ready = ~queue_full;
   assign accept         = req_port.valid & req_port.ready;
   assign v              = req_port.data_byte;
   assign step_nx        = step_ff + 4'd1;

   // Build the parameter byte image with the incoming byte merged in
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         bytes_new[i] = (byte_we && step_ff[2:0] == 3'(i)) ? v : bytes_ff[i];
         image[i*8 +: 8] = bytes_new[i];
      end
   end

   // Classify the request and decide the state update and job
   always_comb begin
      active_cmd_in = active_cmd_ff;
      step_in       = step_ff;
      cursor_in     = cursor_ff;
      ptr_in        = ptr_ff;
      byte_we       = 1'b0;
      push          = '0;
      if (accept) begin
         if (req_port.op) begin
            active_cmd_in = v;
            step_in       = '0;
            priority if (v == gdc_pkg::CMD_RESET) begin
               push.valid             = 1'b1;
               push.job.setting_first = gdc_pkg::SET_DISPLAY_ENABLE;
               push.job.last_offset   = 4'd1;
               push.job.data          = 64'd2;
            end else if (v[7:1] == gdc_pkg::CMD_BLANK[7:1] ||
                         v[7:1] == gdc_pkg::CMD_SYNC[7:1]) begin
               push.valid             = 1'b1;
               push.job.setting_first = gdc_pkg::SET_DISPLAY_ENABLE;
               push.job.data          = {63'd0, v[0]};
               active_cmd_in          = {v[7:1], 1'b0};
            end else if (v == gdc_pkg::CMD_START) begin
               push.valid             = 1'b1;
               push.job.setting_first = gdc_pkg::SET_IDLE;
            end else if (v[7:1] == gdc_pkg::CMD_VSYNC[7:1]) begin
               push.valid             = 1'b1;
               push.job.setting_first = gdc_pkg::SET_MASTER_SYNC;
               push.job.data          = {63'd0, v[0]};
               active_cmd_in          = {v[7:1], 1'b0};
            end else if (v[7:4] == gdc_pkg::CMD_RAMLOAD[7:4]) begin
               ptr_in        = v[3:0];
               active_cmd_in = gdc_pkg::CMD_RAMLOAD;
            end else begin
               active_cmd_in = v;
            end
         end else begin
            priority if (active_cmd_ff == gdc_pkg::CMD_RESET ||
                         active_cmd_ff == gdc_pkg::CMD_SYNC) begin
               // collect eight timing bytes, decode on the last
               if (step_ff < gdc_pkg::TIMING_BYTES) begin
                  byte_we = 1'b1;
                  step_in = step_nx;
                  if (step_nx == gdc_pkg::TIMING_BYTES) begin
                     push.valid             = 1'b1;
                     push.job.setting_first = gdc_pkg::SET_DRAW_RETRACE;
                     push.job.last_offset   = 4'd11;
                     push.job.data          = image;
                  end
               end
            end else if (active_cmd_ff == gdc_pkg::CMD_PITCH) begin
               if (step_ff == '0) begin
                  step_in                = step_nx;
                  push.valid             = 1'b1;
                  push.job.setting_first = gdc_pkg::SET_PITCH;
                  push.job.data          = (v == 8'd0) ? 64'h100 : {56'd0, v};
               end
            end else if (active_cmd_ff == gdc_pkg::CMD_CURPOS) begin
               // cursor address low, middle, then top two bits
               if (step_ff < gdc_pkg::CURSOR_BYTES) begin
                  byte_we = 1'b1;
                  step_in = step_nx;
                  priority if (step_ff == 4'd0) begin
                     cursor_in = {cursor_ff[17:8], v};
                  end else if (step_ff == 4'd1) begin
                     cursor_in = {cursor_ff[17:16], v, cursor_ff[7:0]};
                  end else begin
                     cursor_in = {v[1:0], cursor_ff[15:0]};
                  end
                  push.valid             = 1'b1;
                  push.job.setting_first = gdc_pkg::SET_CURSOR_ADDR;
                  push.job.data          = {46'd0, cursor_in};
               end
            end else if (active_cmd_ff == gdc_pkg::CMD_CURSETUP) begin
               if (step_ff < gdc_pkg::CURSOR_BYTES) begin
                  byte_we = 1'b1;
                  step_in = step_nx;
                  if (step_ff == 4'd0) begin
                     push.valid             = 1'b1;
                     push.job.setting_first = gdc_pkg::SET_CURSOR_ENABLE;
                     push.job.last_offset   = 4'd1;
                     push.job.data          = image;
                  end else if (step_ff == 4'd2) begin
                     push.valid             = 1'b1;
                     push.job.setting_first = gdc_pkg::SET_BLINK_RATE;
                     push.job.last_offset   = 4'd3;
                     push.job.data          = image;
                  end
               end
            end else if (active_cmd_ff == gdc_pkg::CMD_RAMLOAD) begin
               // store at the write pointer, then advance with wrap
               push.valid             = 1'b1;
               push.job.setting_first = gdc_pkg::SET_RAM_BYTE;
               push.job.index         = ptr_ff;
               push.job.data          = {56'd0, v};
               ptr_in = (ptr_ff == gdc_pkg::INDEX_W'(PARAM_RAM_BYTES - 1)) ?
                        '0 : ptr_ff + 4'd1;
            end else begin
               // drop parameters of unknown or blank commands
               step_in = step_ff;
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_cmd_ff <= gdc_pkg::CMD_NONE;
         step_ff       <= '0;
         cursor_ff     <= '0;
         ptr_ff        <= '0;
      end else begin
         active_cmd_ff <= active_cmd_in;
         step_ff       <= step_in;
         cursor_ff     <= cursor_in;
         ptr_ff        <= ptr_in;
      end
   end

   // Parameter bytes, undefined until written
   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         bytes_ff[i] <= bytes_new[i];
      end
   end

   a_timing_at_eighth: assert property (@(posedge clock) disable iff (reset)
      push.valid && push.job.setting_first == gdc_pkg::SET_DRAW_RETRACE
      |=> step_ff == gdc_pkg::TIMING_BYTES)
      else $error("timing decode issued before eighth parameter");

endmodule

>>> design/gdc_queue.sv
// ----------------------------------------------------------------------------
// gdc_queue
// Small job queue between the request decoder and the update expansion.
// ----------------------------------------------------------------------------
module gdc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gdc_pkg::gdc_push_type push,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output gdc_pkg::gdc_job_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gdc_pkg::gdc_job_type mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid;
   assign do_pop     = pop;

   // Advance pointers with wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      do_push |-> !full)
      else $error("job pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      do_pop |-> head_valid)
      else $error("job popped from empty queue");

endmodule

>>> design/gdc_back.sv
// ----------------------------------------------------------------------------
// gdc_back
// Expands each queued job into its run of setting updates, one per cycle
// whenever the output register is free or being taken, into that register.
// ----------------------------------------------------------------------------
module gdc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  gdc_pkg::gdc_job_type head,
   output logic                 pop,
   gdc_rsp_if.source            rsp_port
);

   logic [gdc_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                          out_valid_ff, out_valid_in;
   logic [gdc_pkg::SETTING_W-1:0] setting_ff, setting_cur;
   logic [gdc_pkg::INDEX_W-1:0]   index_ff;
   logic [gdc_pkg::VALUE_W-1:0]   value_ff;
   logic                          last_ff;
   logic                          load;
   logic                          emit;
   logic                          is_last;

   assign load        = ~out_valid_ff | rsp_port.ready;
   assign emit        = load & head_valid;
   assign setting_cur = head.setting_first + {1'b0, step_ff};
   assign is_last     = (step_ff == head.last_offset);
   assign pop         = emit & is_last;

   // Step through the job, restart at the next one
   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = head_valid;
      end
      if (emit) begin
         step_in = is_last ? '0 : step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (emit) begin
         setting_ff <= setting_cur;
         index_ff   <= head.index;
         value_ff   <= gdc_pkg::setting_value(setting_cur, head.data);
         last_ff    <= is_last;
      end
   end

   assign rsp_port.valid   = out_valid_ff;
   assign rsp_port.setting = setting_ff;
   assign rsp_port.index   = index_ff;
   assign rsp_port.value   = value_ff;
   assign rsp_port.last    = last_ff;

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> step_ff <= head.last_offset)
      else $error("expansion step past end of job");

   a_step_restart: assert property (@(posedge clock) disable iff (reset)
      pop |=> step_ff == '0)
      else $error("expansion step not cleared after job");

endmodule

>>> tb/tb_gdc_command_parser_top.sv
// ----------------------------------------------------------------------------
// tb_gdc_command_parser_top
// Self-checking bench for the display controller command parser. Requests
// (command and parameter bytes) go in over a valid/ready channel with random
// gaps. A behavioral decoder predicts the updates of untyped requests; typed
// rows carry theirs. Responses stall at random, each update compared field by
// field in order. A directed table comes first, then random command bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gdc_command_parser_top;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 7;
   localparam int NUM_REQS     = 350;
   localparam int TAIL_CYCLES  = 30;
   localparam int RAM_BYTES    = 16;
   localparam int DIR_ROWS     = 29;

   typedef struct packed {
      logic [gdc_pkg::SETTING_W-1:0] setting;
      logic [gdc_pkg::INDEX_W-1:0]   index;
      logic [gdc_pkg::VALUE_W-1:0]   value;
      logic                          last;
   } update_type;

   // One directed request; typed rows carry their updates, the rest use the decoder
   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic       typed;
      logic [1:0] n_typed;
      update_type u0;
      update_type u1;
   } script_row_type;

   localparam update_type NO_UPD = '0;

   logic clock;
   logic reset;

   gdc_req_if req_bus ();
   gdc_rsp_if rsp_bus ();

   gdc_command_parser_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Decoder state
   logic [7:0]                  cur_cmd;
   logic [gdc_pkg::STEP_W-1:0]  step_cnt;
   logic [7:0]                  parm [8];
   logic [gdc_pkg::VALUE_W-1:0] cursor_q;
   logic [gdc_pkg::INDEX_W-1:0] ram_ptr;

   update_type decoded[$];
   update_type pending_updates[$];
   update_type want;

   int  fail_cnt       = 0;
   int  useful_reqs    = 0;
   int  total_reqs     = 0;
   int  updates_seen   = 0;
   int  timing_decodes = 0;
   int  drains         = 0;
   int  stall_left     = 0;
   bit  req_quiet      = 0;
   bit  rsp_quiet      = 0;

   script_row_type dir_script [DIR_ROWS] = '{
      // parameter with no command yet: ignored
      '{1'b0, 8'h55, 1'b1, 2'd0, NO_UPD, NO_UPD},
      '{1'b1, gdc_pkg::CMD_RESET, 1'b1, 2'd2,
        '{gdc_pkg::SET_DISPLAY_ENABLE, 4'd0, 18'd0, 1'b0},
        '{gdc_pkg::SET_IDLE, 4'd0, 18'd1, 1'b0}},
      // eight timing bytes, extremes of each field
      '{1'b0, 8'h3F, 1'b0, 2'd0, NO_UPD, NO_UPD},
      '{1'b0, 8'hFF, 1'b0, 2'd0, NO_UPD, NO_UPD},
      '{1'b0, 8'h00, 1'b0, 2'd0, NO_UPD, NO_UPD},
      '{1'b0, 8'hFF, 1'b0, 2'd0, NO_UPD, NO_UPD},
      '{1'b0, 8'h3F, 1'b0, 2'd0, NO_UPD, NO_UPD},
      '{1'b0, 8'h3F, 1'b0, 2'd0, NO_UPD, NO_UPD},
      '{1'b0, 8'hFF, 1'b0, 2'd0, NO_UPD, NO_UPD},
      '{1'b0, 8'hFF, 1'b0, 2'd0, NO_UPD, NO_UPD},
      // surplus timing byte
      '{1'b0, 8'hFF, 1'b1, 2'd0, NO_UPD, NO_UPD},
      '{1'b1, 8'h0D, 1'b1, 2'd1,
        '{gdc_pkg::SET_DISPLAY_ENABLE, 4'd0, 18'd1, 1'b0}, NO_UPD},
      // blank takes no parameters
      '{1'b0, 8'h77, 1'b1, 2'd0, NO_UPD, NO_UPD},
      '{1'b1, gdc_pkg::CMD_PITCH, 1'b1, 2'd0, NO_UPD, NO_UPD},
      '{1'b0, 8'h00, 1'b1, 2'd1,
        '{gdc_pkg::SET_PITCH, 4'd0, 18'h100, 1'b0}, NO_UPD},
      '{1'b1, gdc_pkg::CMD_CURPOS, 1'b1, 2'd0, NO_UPD, NO_UPD},
      '{1'b0, 8'hFF, 1'b1, 2'd1,
        '{gdc_pkg::SET_CURSOR_ADDR, 4'd0, 18'h000FF, 1'b0}, NO_UPD},
      '{1'b0, 8'hFF, 1'b1, 2'd1,
        '{gdc_pkg::SET_CURSOR_ADDR, 4'd0, 18'h0FFFF, 1'b0}, NO_UPD},
      '{1'b0, 8'hFF, 1'b1, 2'd1,
        '{gdc_pkg::SET_CURSOR_ADDR, 4'd0, 18'h3FFFF, 1'b0}, NO_UPD},
      '{1'b1, gdc_pkg::CMD_CURSETUP, 1'b1, 2'd0, NO_UPD, NO_UPD},
      '{1'b0, 8'h9F, 1'b1, 2'd2,
        '{gdc_pkg::SET_CURSOR_ENABLE, 4'd0, 18'd1, 1'b0},
        '{gdc_pkg::SET_ROW_LINES, 4'd0, 18'h1F, 1'b0}},
      '{1'b0, 8'h00, 1'b1, 2'd0, NO_UPD, NO_UPD},
      // zero blink rate on the third cursor byte
      '{1'b0, 8'h00, 1'b0, 2'd0, NO_UPD, NO_UPD},
      '{1'b1, 8'h6F, 1'b1, 2'd1,
        '{gdc_pkg::SET_MASTER_SYNC, 4'd0, 18'd1, 1'b0}, NO_UPD},
      '{1'b1, 8'h7F, 1'b1, 2'd0, NO_UPD, NO_UPD},
      '{1'b0, 8'hAA, 1'b1, 2'd1,
        '{gdc_pkg::SET_RAM_BYTE, 4'd15, 18'hAA, 1'b0}, NO_UPD},
      // write pointer wraps to zero
      '{1'b0, 8'h00, 1'b1, 2'd1,
        '{gdc_pkg::SET_RAM_BYTE, 4'd0, 18'h00, 1'b0}, NO_UPD},
      // unknown command
      '{1'b1, 8'h20, 1'b1, 2'd0, NO_UPD, NO_UPD},
      '{1'b1, gdc_pkg::CMD_START, 1'b1, 2'd1,
        '{gdc_pkg::SET_IDLE, 4'd0, 18'd0, 1'b0}, NO_UPD}
   };

   // Free-running clock
   always #CLK_HALF clock = ~clock;

   function automatic update_type mk(input logic [gdc_pkg::SETTING_W-1:0] setting,
                                     input int unsigned                   index,
                                     input int unsigned                   value);
      update_type u;
      u.setting = setting;
      u.index   = index[gdc_pkg::INDEX_W-1:0];
      u.value   = value[gdc_pkg::VALUE_W-1:0];
      u.last    = 1'b0;
      return u;
   endfunction

   function automatic int pick_idle(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
         fail_cnt++;
      end
   endfunction

   // Decode one request into the setting updates it causes (left in decoded)
   task automatic decode_request(input logic is_cmd, input logic [7:0] b);
      logic [7:0] pair;
      logic [5:0] blink;
      decoded.delete();
      pair = {b[7:1], 1'b0};
      if (is_cmd) begin
         cur_cmd  = b;
         step_cnt = '0;
         if (b == gdc_pkg::CMD_RESET) begin
            decoded.push_back(mk(gdc_pkg::SET_DISPLAY_ENABLE, 0, 0));
            decoded.push_back(mk(gdc_pkg::SET_IDLE, 0, 1));
         end else if (pair == gdc_pkg::CMD_BLANK || pair == gdc_pkg::CMD_SYNC) begin
            decoded.push_back(mk(gdc_pkg::SET_DISPLAY_ENABLE, 0, b[0]));
            cur_cmd = pair;
         end else if (b == gdc_pkg::CMD_START) begin
            decoded.push_back(mk(gdc_pkg::SET_IDLE, 0, 0));
         end else if (pair == gdc_pkg::CMD_VSYNC) begin
            decoded.push_back(mk(gdc_pkg::SET_MASTER_SYNC, 0, b[0]));
            cur_cmd = pair;
         end else if (b[7:4] == gdc_pkg::CMD_RAMLOAD[7:4]) begin
            ram_ptr = b[3:0];
            cur_cmd = gdc_pkg::CMD_RAMLOAD;
         end
      end else if (cur_cmd == gdc_pkg::CMD_RESET || cur_cmd == gdc_pkg::CMD_SYNC) begin
         // collect timing bytes, decode all twelve fields on the last one
         if (step_cnt < gdc_pkg::TIMING_BYTES) begin
            parm[step_cnt[2:0]] = b;
            step_cnt = step_cnt + 1'b1;
            if (step_cnt == gdc_pkg::TIMING_BYTES) begin
               decoded.push_back(mk(gdc_pkg::SET_DRAW_RETRACE, 0, parm[0][4]));
               decoded.push_back(mk(gdc_pkg::SET_REFRESH, 0, parm[0][2]));
               decoded.push_back(mk(gdc_pkg::SET_DISPLAY_MODE, 0,
                                    {parm[0][5], parm[0][1]}));
               decoded.push_back(mk(gdc_pkg::SET_FRAMING, 0, {parm[0][3], parm[0][0]}));
               decoded.push_back(mk(gdc_pkg::SET_ACTIVE_WORDS, 0, parm[1] + 2));
               decoded.push_back(mk(gdc_pkg::SET_HSYNC_WIDTH, 0, parm[2][4:0] + 1));
               decoded.push_back(mk(gdc_pkg::SET_VSYNC_WIDTH, 0,
                                    {parm[3][1:0], parm[2][7:5]}));
               decoded.push_back(mk(gdc_pkg::SET_H_FRONT, 0, parm[3][7:2] + 1));
               decoded.push_back(mk(gdc_pkg::SET_H_BACK, 0, parm[4][5:0] + 1));
               decoded.push_back(mk(gdc_pkg::SET_V_FRONT, 0, parm[5][5:0]));
               decoded.push_back(mk(gdc_pkg::SET_ACTIVE_LINES, 0,
                                    {parm[7][1:0], parm[6]}));
               decoded.push_back(mk(gdc_pkg::SET_V_BACK, 0, parm[7][7:2]));
            end
         end
      end else if (cur_cmd == gdc_pkg::CMD_PITCH) begin
         if (step_cnt < 1) begin
            step_cnt = step_cnt + 1'b1;
            decoded.push_back(mk(gdc_pkg::SET_PITCH, 0, (b != 0) ? 18'(b) : 18'h100));
         end
      end else if (cur_cmd == gdc_pkg::CMD_CURPOS) begin
         if (step_cnt < gdc_pkg::CURSOR_BYTES) begin
            parm[step_cnt[2:0]] = b;
            step_cnt = step_cnt + 1'b1;
            if (step_cnt == 1) cursor_q[7:0] = b;
            else if (step_cnt == 2) cursor_q[15:8] = b;
            else cursor_q[17:16] = b[1:0];
            decoded.push_back(mk(gdc_pkg::SET_CURSOR_ADDR, 0, cursor_q));
         end
      end else if (cur_cmd == gdc_pkg::CMD_CURSETUP) begin
         if (step_cnt < gdc_pkg::CURSOR_BYTES) begin
            parm[step_cnt[2:0]] = b;
            step_cnt = step_cnt + 1'b1;
            if (step_cnt == 1) begin
               decoded.push_back(mk(gdc_pkg::SET_CURSOR_ENABLE, 0, parm[0][7]));
               decoded.push_back(mk(gdc_pkg::SET_ROW_LINES, 0, parm[0][4:0]));
            end else if (step_cnt == 3) begin
               // a zero blink rate stands for 0x20
               blink = {1'b0, parm[2][2:0], parm[1][7:6]};
               if (blink == 0) blink = 6'h20;
               decoded.push_back(mk(gdc_pkg::SET_BLINK_RATE, 0, blink * 2));
               decoded.push_back(mk(gdc_pkg::SET_BLINKING, 0, !parm[1][5]));
               decoded.push_back(mk(gdc_pkg::SET_CURSOR_TOP, 0, parm[1][4:0]));
               decoded.push_back(mk(gdc_pkg::SET_CURSOR_BOTTOM, 0, parm[2][7:3]));
            end
         end
      end else if (cur_cmd == gdc_pkg::CMD_RAMLOAD) begin
         decoded.push_back(mk(gdc_pkg::SET_RAM_BYTE, ram_ptr, b));
         ram_ptr = (int'(ram_ptr) == RAM_BYTES - 1) ? '0 : ram_ptr + 1'b1;
      end
      if (decoded.size() > 0) decoded[decoded.size()-1].last = 1'b1;
   endtask

   // Drive one request, wait for the handshake, then record its updates
   task automatic send_request(input logic op, input logic [7:0] b, input logic typed,
                               input int n_typed, input update_type t0,
                               input update_type t1);
      int gap;
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.data_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      decode_request(op, b);
      if (typed) begin
         decoded.delete();
         if (n_typed >= 1) decoded.push_back(t0);
         if (n_typed >= 2) decoded.push_back(t1);
         if (decoded.size() > 0) decoded[decoded.size()-1].last = 1'b1;
      end
      total_reqs++;
      if (op || decoded.size() > 0) useful_reqs++;
      if (decoded.size() == 12) timing_decodes++;
      foreach (decoded[i]) pending_updates.push_back(decoded[i]);
      // idle the request side for a while
      gap = pick_idle(req_quiet);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Hold off new requests until every outstanding update has arrived
   task automatic drain_updates();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_updates.size() > 0) @(posedge clock);
      drains++;
   endtask

   // One command followed by parameter bytes; optionally clear the blink rate bits
   task automatic send_burst(input logic [7:0] cmd, input int nparm, input bit zero_blink);
      logic [7:0] b;
      send_request(1'b1, cmd, 1'b0, 0, NO_UPD, NO_UPD);
      for (int i = 0; i < nparm; i++) begin
         b = rand_byte();
         if (zero_blink && i == 1) b = b & 8'h3F;
         if (zero_blink && i == 2) b = b & 8'hF8;
         send_request(1'b0, b, 1'b0, 0, NO_UPD, NO_UPD);
      end
   endtask

   // Stall the update side at random, with quiet stretches
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left    <= pick_idle(rsp_quiet);
      end
      if ($urandom_range(0, 63) == 0) rsp_quiet <= ~rsp_quiet;
   end

   // Compare each accepted update with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_updates.size() == 0) begin
            $error("unexpected update: setting %0d index %0d value %0h last %0b",
                   rsp_bus.setting, rsp_bus.index, rsp_bus.value, rsp_bus.last);
            fail_cnt++;
         end else begin
            want = pending_updates.pop_front();
            check_field("setting", want.setting, rsp_bus.setting);
            check_field("index", want.index, rsp_bus.index);
            check_field("value", want.value, rsp_bus.value);
            check_field("last", want.last, rsp_bus.last);
            updates_seen++;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int kind;
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.op        = 1'b0;
      req_bus.data_byte = 8'h00;
      rsp_bus.ready     = 1'b0;
      cur_cmd           = gdc_pkg::CMD_NONE;
      step_cnt          = '0;
      cursor_q          = '0;
      ram_ptr           = '0;
      foreach (parm[i]) parm[i] = 8'h00;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (dir_script[i]) begin
         send_request(dir_script[i].op, dir_script[i].data_byte, dir_script[i].typed,
                      dir_script[i].n_typed, dir_script[i].u0, dir_script[i].u1);
      end
      drain_updates();

      // random command bursts, mostly well formed
      while (total_reqs < NUM_REQS) begin
         kind = $urandom_range(0, 19);
         if (kind < 4) begin
            send_burst((kind < 2) ? gdc_pkg::CMD_RESET
                       : (gdc_pkg::CMD_SYNC | 8'($urandom_range(0, 1))),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(3, 11) : 8, 1'b0);
         end else if (kind < 6) begin
            send_burst(gdc_pkg::CMD_BLANK | 8'($urandom_range(0, 1)),
                       $urandom_range(0, 2), 1'b0);
         end else if (kind < 8) begin
            send_burst(gdc_pkg::CMD_PITCH, ($urandom_range(0, 3) == 0) ? 2 : 1, 1'b0);
         end else if (kind < 11) begin
            send_burst(gdc_pkg::CMD_CURPOS,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 3, 1'b0);
         end else if (kind < 14) begin
            send_burst(gdc_pkg::CMD_CURSETUP,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 3,
                       $urandom_range(0, 3) == 0);
         end else if (kind == 14) begin
            send_burst(($urandom_range(0, 1) == 0) ? gdc_pkg::CMD_START
                       : (gdc_pkg::CMD_VSYNC | 8'($urandom_range(0, 1))), 0, 1'b0);
         end else if (kind < 17) begin
            send_burst(gdc_pkg::CMD_RAMLOAD | 8'($urandom_range(0, 15)),
                       $urandom_range(1, 20), 1'b0);
         end else if (kind < 19) begin
            // noise: arbitrary words
            repeat ($urandom_range(1, 4)) begin
               send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 0,
                            NO_UPD, NO_UPD);
            end
         end else begin
            send_burst(8'($urandom_range(0, 255)), $urandom_range(0, 3), 1'b0);
         end
         if ($urandom_range(0, 15) == 0) req_quiet = ~req_quiet;
         if ($urandom_range(0, 29) == 0) drain_updates();
      end

      // let everything arrive, then watch for stray updates
      drain_updates();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d with effect), checked %0d setting updates.",
               total_reqs, useful_reqs, updates_seen);
      $display("Included %0d full timing decodes and %0d idle drains.",
               timing_decodes, drains);
      if (fail_cnt == 0 && pending_updates.size() == 0) begin
         $display("PASS gdc_command_parser_top");
      end else begin
         $display("FAIL gdc_command_parser_top");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("FAIL gdc_command_parser_top");
      $finish;
   end

endmodule
